/* design/mac_pkg.sv */
// Shared types and constants of the moving average crossover block.
// Holds the field widths, reset values, action and register index codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mac_pkg;

  // Default sizing
  localparam int HISTORY_DEPTH = 32;
  localparam int CHANNELS      = 3;
  localparam int PRICE_BITS    = 40;

  // Fixed field widths
  localparam int AMOUNT_W  = 40;
  localparam int WIN_W     = 6;
  localparam int SYM_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Symbol code that never maps to a channel
  localparam logic [SYM_W-1:0] SYM_UNKNOWN = 2'd3;

  // Register reset values
  localparam logic [WIN_W-1:0]    SHORT_WINDOW_RST = 6'd5;
  localparam logic [WIN_W-1:0]    LONG_WINDOW_RST  = 6'd20;
  localparam logic [AMOUNT_W-1:0] TRADE_VOLUME_RST = 40'd6553600;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_WINDOW = 2'd0,
    CFG_LONG_WINDOW  = 2'd1,
    CFG_TRADE_VOLUME = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [WIN_W-1:0]    short_window;
    logic [WIN_W-1:0]    long_window;
    logic [AMOUNT_W-1:0] trade_volume;
  } cfg_t;

  // Per-item side data carried down the pipeline
  typedef struct packed {
    logic                known;
    logic [SYM_W-1:0]    ch;
    logic [AMOUNT_W-1:0] wallet;
    logic [AMOUNT_W-1:0] held;
  } item_t;

  typedef struct packed {
    action_e             action;
    logic [AMOUNT_W-1:0] order_amount;
    logic                trend_above;
  } result_t;

endpackage

`default_nettype wire

/* design/mac_if.sv */
// Valid/ready channel interfaces of the moving average crossover block.
// mac_in_if carries price samples, mac_out_if carries trade results.
// Depends on mac_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface mac_in_if #(
  parameter int PriceBits = mac_pkg::PRICE_BITS
);
  logic                          valid;
  logic                          ready;
  logic [mac_pkg::SYM_W-1:0]     symbol_index;
  logic [PriceBits-1:0]          price;
  logic [mac_pkg::AMOUNT_W-1:0]  wallet_funds;
  logic [mac_pkg::AMOUNT_W-1:0]  usd_held;

  modport source (output valid, symbol_index, price, wallet_funds, usd_held, input ready);
  modport sink   (input valid, symbol_index, price, wallet_funds, usd_held, output ready);
endinterface

interface mac_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [mac_pkg::AMOUNT_W-1:0]  order_amount;
  logic                          trend_above;

  modport source (output valid, action, order_amount, trend_above, input ready);
  modport sink   (input valid, action, order_amount, trend_above, output ready);
endinterface

`default_nettype wire

/* design/mac_decide.sv */
// Crossover decision: cross-multiplies the window sums, compares them,
// updates the per-channel trend flags and holds the result register.
// Depends on mac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mac_decide #(
  parameter int SumW  = 45,
  parameter int NumCh = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mac_pkg::cfg_t         cfg_i,
  input  wire logic                  in_valid_i,
  input  wire mac_pkg::item_t        in_item_i,
  input  wire logic [SumW-1:0]       short_sum_i,
  input  wire logic [SumW-1:0]       long_sum_i,
  output      logic                  adv_o,
  output      logic                  res_valid_o,
  output      mac_pkg::result_t      res_o,
  input  wire logic                  res_ready_i
);

  localparam int ProdW = SumW + mac_pkg::WIN_W;

  logic                  s3_valid_q;
  mac_pkg::item_t        s3_item_q;
  logic [ProdW-1:0]      prod_s_q;
  logic [ProdW-1:0]      prod_l_q;
  logic                  pos_q;
  logic [NumCh-1:0]      trend_q;
  logic                  out_valid_q;
  mac_pkg::result_t      res_q;
  mac_pkg::result_t      res_d;
  logic                  flag_d;
  logic [mac_pkg::SYM_W-1:0] ch_sel;
  logic                  flag;
  logic                  rises;
  logic                  falls;

  // Whole pipe moves when the result register is free or being drained
  assign adv_o = !out_valid_q || res_ready_i;

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv_o) begin
      s3_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s3_item_q <= in_item_i;
      prod_s_q  <= ProdW'(short_sum_i) * ProdW'(cfg_i.long_window);
      prod_l_q  <= ProdW'(long_sum_i) * ProdW'(cfg_i.short_window);
      pos_q     <= (short_sum_i != '0) && (long_sum_i != '0);
    end
  end

  // Compare and flag update
  assign ch_sel = s3_item_q.known ? s3_item_q.ch : '0;
  assign flag   = trend_q[ch_sel];
  assign rises  = prod_s_q > prod_l_q;
  assign falls  = prod_s_q < prod_l_q;

  always_comb begin
    res_d  = '{action: mac_pkg::ACT_NONE, order_amount: '0, trend_above: 1'b0};
    flag_d = flag;
    if (s3_item_q.known) begin
      if (pos_q) begin
        if (!flag && rises) begin
          flag_d = 1'b1;
          if (s3_item_q.wallet >= cfg_i.trade_volume) begin
            res_d.action       = mac_pkg::ACT_BUY;
            res_d.order_amount = cfg_i.trade_volume;
          end
        end else if (flag && falls) begin
          flag_d             = 1'b0;
          res_d.action       = mac_pkg::ACT_SELL;
          res_d.order_amount = s3_item_q.held;
        end
      end
      res_d.trend_above = flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trend_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= s3_valid_q;
      if (s3_valid_q && s3_item_q.known) begin
        trend_q[ch_sel] <= flag_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  // A buy leaves the flag set, a sell leaves it clear
  a_buy_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.action == mac_pkg::ACT_BUY) |-> res_q.trend_above)
    else $error("buy with trend flag clear");

  a_sell_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.action == mac_pkg::ACT_SELL) |-> !res_q.trend_above)
    else $error("sell with trend flag set");

  a_none_no_amount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.action == mac_pkg::ACT_NONE) |-> (res_q.order_amount == '0))
    else $error("order amount without an order");

endmodule

`default_nettype wire

/* design/moving_average_crossover_core.sv */
// Moving average crossover core: history memory of prefix sums, window sum
// stage and the decision unit. Depends on mac_pkg, mac_in_if, mac_out_if
// and mac_decide.
//
// Usage:
//   sample_i takes one price sample per transfer for channel symbol_index
//   (0..2; symbol 3 or a channel beyond the configured count is ignored and
//   yields action none, amount 0, flag 0). result_o gives exactly one result
//   per sample, in order. Registers are written on cfg_we_i with cfg_idx_i
//   (0 short window, 1 long window, 2 trade volume); the user writes them
//   only while the core is idle; the core does not enforce this.
// Throughput:
//   One sample per cycle unless stalled. Each sample reads the history
//   memory at two addresses (start of the short and the long window) and
//   writes the new prefix sum in the same cycle; those ports set the rate.
// Reset:
//   Clears counts, pointers, running totals, trend flags and the pipeline.
//   The history memory is not cleared; only entries within a channel's
//   sample count are used. No clearing pass is needed.
// Stall:
//   When result_o is not taken, every stage holds and sample_i.ready drops
//   until the result register drains.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_crossover_core #(
  parameter int HistoryDepth = mac_pkg::HISTORY_DEPTH,
  parameter int Channels     = mac_pkg::CHANNELS,
  parameter int PriceBits    = mac_pkg::PRICE_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  mac_in_if.sink                                 sample_i,
  mac_out_if.source                              result_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [mac_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [mac_pkg::AMOUNT_W-1:0]      cfg_data_i
);

  localparam int NumCh    = (Channels < 3) ? Channels : 3;
  localparam int PtrW     = $clog2(HistoryDepth);
  localparam int CntW     = $clog2(HistoryDepth + 1);
  localparam int SumW     = PriceBits + $clog2(HistoryDepth);
  localparam int MemDepth = NumCh * HistoryDepth;
  localparam int AddrW    = $clog2(MemDepth);
  localparam int WinW     = mac_pkg::WIN_W;
  localparam int CmpW     = ((CntW > WinW) ? CntW : WinW) + 1;
  localparam int SlotW    = ((PtrW > WinW) ? PtrW : WinW) + 1;

  // Configuration registers
  mac_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_window <= mac_pkg::SHORT_WINDOW_RST;
      cfg_q.long_window  <= mac_pkg::LONG_WINDOW_RST;
      cfg_q.trade_volume <= mac_pkg::TRADE_VOLUME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mac_pkg::CFG_SHORT_WINDOW: cfg_q.short_window <= cfg_data_i[WinW-1:0];
        mac_pkg::CFG_LONG_WINDOW:  cfg_q.long_window  <= cfg_data_i[WinW-1:0];
        mac_pkg::CFG_TRADE_VOLUME: cfg_q.trade_volume <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Window helpers
  function automatic logic win_ok(input logic [WinW-1:0] w, input logic [CntW-1:0] c);
    win_ok = (w != '0) && (CmpW'(w) <= CmpW'(HistoryDepth)) && (CmpW'(w) <= CmpW'(c));
  endfunction

  // Ring slot holding the prefix sum just before the window of w samples
  function automatic logic [PtrW-1:0] start_slot(input logic [PtrW-1:0] p,
                                                 input logic [WinW-1:0] w);
    logic [SlotW-1:0] pe;
    logic [SlotW-1:0] we;
    logic [SlotW-1:0] d;
    pe = SlotW'(p);
    we = SlotW'(w);
    d  = (pe >= we) ? (pe - we) : (pe + SlotW'(HistoryDepth) - we);
    start_slot = d[PtrW-1:0];
  endfunction

  // Per-channel state
  logic [CntW-1:0] cnt_q [NumCh];
  logic [PtrW-1:0] ptr_q [NumCh];
  logic [SumW-1:0] tot_q [NumCh];

  // History memory of prefix sums
  logic [SumW-1:0] mem [MemDepth];
  logic [SumW-1:0] rd_s_q;
  logic [SumW-1:0] rd_l_q;

  logic                      adv;
  logic                      acc;
  logic                      known;
  logic [mac_pkg::SYM_W-1:0] ch_sel;
  logic [CntW-1:0]           cnt;
  logic [CntW-1:0]           cnt_new;
  logic                      sat;
  logic [PtrW-1:0]           ptr;
  logic [PtrW-1:0]           ptr_new;
  logic [SumW-1:0]           p_new;
  logic                      sv;
  logic                      lv;
  logic                      zb_s;
  logic                      zb_l;
  logic [AddrW-1:0]          base_addr;
  logic [AddrW-1:0]          addr_s;
  logic [AddrW-1:0]          addr_l;
  logic [AddrW-1:0]          addr_w;
  mac_pkg::item_t            item_d;

  assign sample_i.ready = adv;
  assign acc   = sample_i.valid && sample_i.ready;
  assign known = (sample_i.symbol_index != mac_pkg::SYM_UNKNOWN) &&
                 (32'(sample_i.symbol_index) < NumCh);
  assign ch_sel = known ? sample_i.symbol_index : '0;

  // Sample admission: new prefix, addresses of both window starts
  assign cnt     = cnt_q[ch_sel];
  assign ptr     = ptr_q[ch_sel];
  assign sat     = (cnt == CntW'(HistoryDepth));
  assign cnt_new = sat ? cnt : cnt + CntW'(1);
  assign ptr_new = (ptr == PtrW'(HistoryDepth - 1)) ? '0 : ptr + PtrW'(1);
  assign p_new   = tot_q[ch_sel] + SumW'(sample_i.price);

  assign sv   = known && win_ok(cfg_q.short_window, cnt_new);
  assign lv   = known && win_ok(cfg_q.long_window, cnt_new);
  assign zb_s = !sat && (CmpW'(cfg_q.short_window) == CmpW'(cnt_new));
  assign zb_l = !sat && (CmpW'(cfg_q.long_window) == CmpW'(cnt_new));

  assign base_addr = AddrW'(ch_sel) * AddrW'(HistoryDepth);
  assign addr_s    = base_addr + AddrW'(start_slot(ptr, cfg_q.short_window));
  assign addr_l    = base_addr + AddrW'(start_slot(ptr, cfg_q.long_window));
  assign addr_w    = base_addr + AddrW'(ptr);

  assign item_d = '{known:  known,
                    ch:     ch_sel,
                    wallet: sample_i.wallet_funds,
                    held:   sample_i.usd_held};

  // Channel state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        cnt_q[i] <= '0;
        ptr_q[i] <= '0;
        tot_q[i] <= '0;
      end
    end else if (acc && known) begin
      cnt_q[ch_sel] <= cnt_new;
      ptr_q[ch_sel] <= ptr_new;
      tot_q[ch_sel] <= p_new;
    end
  end

  // Memory: two reads of old contents, one write of the new prefix
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_s_q <= mem[addr_s];
      rd_l_q <= mem[addr_l];
      if (known) begin
        mem[addr_w] <= p_new;
      end
    end
  end

  // Stage 1: memory data arrives
  logic                 s1_valid_q;
  mac_pkg::item_t       s1_item_q;
  logic [SumW-1:0]      s1_pnew_q;
  logic                 s1_sv_q;
  logic                 s1_lv_q;
  logic                 s1_zbs_q;
  logic                 s1_zbl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_item_q <= item_d;
      s1_pnew_q <= p_new;
      s1_sv_q   <= sv;
      s1_lv_q   <= lv;
      s1_zbs_q  <= zb_s;
      s1_zbl_q  <= zb_l;
    end
  end

  // Window sums as prefix differences
  logic [SumW-1:0] sum_s_d;
  logic [SumW-1:0] sum_l_d;

  always_comb begin
    sum_s_d = '0;
    sum_l_d = '0;
    if (s1_sv_q) begin
      sum_s_d = s1_zbs_q ? s1_pnew_q : s1_pnew_q - rd_s_q;
    end
    if (s1_lv_q) begin
      sum_l_d = s1_zbl_q ? s1_pnew_q : s1_pnew_q - rd_l_q;
    end
  end

  // Stage 2: sums registered
  logic                 s2_valid_q;
  mac_pkg::item_t       s2_item_q;
  logic [SumW-1:0]      s2_sum_s_q;
  logic [SumW-1:0]      s2_sum_l_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_item_q  <= s1_item_q;
      s2_sum_s_q <= sum_s_d;
      s2_sum_l_q <= sum_l_d;
    end
  end

  // Decision unit and result register
  mac_pkg::result_t res;
  logic             res_valid;

  mac_decide #(
    .SumW  (SumW),
    .NumCh (NumCh)
  ) u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s2_valid_q),
    .in_item_i   (s2_item_q),
    .short_sum_i (s2_sum_s_q),
    .long_sum_i  (s2_sum_l_q),
    .adv_o       (adv),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (result_o.ready)
  );

  assign result_o.valid        = res_valid;
  assign result_o.action       = res.action;
  assign result_o.order_amount = res.order_amount;
  assign result_o.trend_above  = res.trend_above;

  // Channel state stays in range
  for (genvar g = 0; g < NumCh; g++) begin : g_chk
    a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      32'(ptr_q[g]) < HistoryDepth)
      else $error("history pointer beyond depth");

    a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      32'(cnt_q[g]) <= HistoryDepth)
      else $error("sample count beyond depth");
  end

  // A transfer of an ignored symbol leaves the channel state alone
  a_unknown_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !known) |=> ($stable(cnt_q[0]) && $stable(ptr_q[0])))
    else $error("ignored symbol changed channel state");

endmodule

`default_nettype wire
